[rtl/smx_pkg.sv]
// shared types and constants for the sparse matrix store
// no dependencies; used by the rtl and the testbench

package smx_pkg;

   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 7;
   localparam int CFG_IDX_W   = 1;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

   typedef enum logic [1:0] {
      ALU_PASS,
      ALU_INC,
      ALU_DEC,
      ALU_DEC_SAT
   } alu_op_type;

   typedef struct packed {
      logic lt;
      logic gt;
   } alu_cmp_type;

endpackage

[rtl/smx_alu.sv]
// shared step unit: pass, increment, decrement or saturating decrement with compares
// depends on smx_pkg

module smx_alu #(
   parameter int W = 9
) (
   input  smx_pkg::alu_op_type  op,
   input  logic [W-1:0]         a,
   input  logic [W-1:0]         b,
   output logic [W-1:0]         res,
   output smx_pkg::alu_cmp_type cmp
);

   always_comb begin
      case (op)
         smx_pkg::ALU_PASS:    res = a;
         smx_pkg::ALU_INC:     res = a + W'(1);
         smx_pkg::ALU_DEC:     res = a - W'(1);
         smx_pkg::ALU_DEC_SAT: res = (a == '0) ? a : a - W'(1);
         default:              res = a;
      endcase
   end

   assign cmp.lt = (res < b);
   assign cmp.gt = (a > b);

endmodule

[rtl/smx_ptr_ram.sv]
// row pointer memory with per-entry valid bits, an invalid entry reads as zero
// no dependencies; used by sparse_matrix_store

module smx_ptr_ram #(
   parameter  int DEPTH = 65,
   parameter  int W     = 9,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [W-1:0]     rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

[rtl/smx_entry_ram.sv]
// entry memory holding column index and value of each stored nonzero
// no dependencies; used by sparse_matrix_store

module smx_entry_ram #(
   parameter  int DEPTH = 256,
   parameter  int W     = 38,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sparse_matrix_store.sv]
// sparse matrix store in compressed row form, top level with sequencer
// out of range skips to the response; else, on single ram ports, both row pointers are read
// and the row scanned to the first column at or past the one asked for or to its end; a write
// rewrites a found entry, or shifts entries by one and sweeps pointers row+1 to min(MAX_ROWS,64)
// one request at a time, next accept once the response loads, which may then wait
// reset: synchronous, clears row pointer valid bits and entry count at once, dims to 64
// depends on smx_pkg, smx_alu, smx_ptr_ram, smx_entry_ram

module sparse_matrix_store #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [smx_pkg::REQ_TDATA_W-1:0]     req_tdata,  // row, col, value, zero pad
   input  logic                                req_tuser,  // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smx_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // old_value, status, zero pad
   input  logic                                csr_we,
   input  logic [smx_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [smx_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int RAW     = $clog2(ROW_LIM + 1);
   localparam int PW      = $clog2(CAPACITY + 1);
   localparam int EAW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int EW      = smx_pkg::COL_W + VALUE_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PTR_LO,
      ST_PTR_HI,
      ST_PTR_DONE,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_DECIDE,
      ST_DEL_MOVE,
      ST_INS_MOVE,
      ST_INS_PUT,
      ST_SWP_START,
      ST_SWP_MOVE,
      ST_FINISH
   } state_type;

   state_type                          state_ff, state_in;
   logic                               op_ff, op_in;
   logic [smx_pkg::ROW_W-1:0]          row_ff, row_in;
   logic [smx_pkg::COL_W-1:0]          col_ff, col_in;
   logic [VALUE_WIDTH-1:0]             val_ff, val_in;
   logic [PW-1:0]                      lo_ff, lo_in;
   logic [PW-1:0]                      hi_ff, hi_in;
   logic [PW-1:0]                      k_ff, k_in;
   logic [PW-1:0]                      idx_ff, idx_in;
   logic [PW-1:0]                      wr_ff, wr_in;
   logic [PW-1:0]                      cnt_ff, cnt_in;
   logic [RAW-1:0]                     p_ff, p_in;
   logic                               dec_ff, dec_in;
   logic                               found_ff, found_in;
   logic [VALUE_WIDTH-1:0]             old_ff, old_in;
   logic [smx_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [smx_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [smx_pkg::CFG_W-1:0]          row_count_ff, row_count_in;
   logic [smx_pkg::CFG_W-1:0]          col_count_ff, col_count_in;

   logic                               ptr_we;
   logic [RAW-1:0]                     ptr_wa, ptr_ra;
   logic [PW-1:0]                      ptr_wd, ptr_rdata;
   logic                               ent_we;
   logic [EAW-1:0]                     ent_wa, ent_ra;
   logic [EW-1:0]                      ent_wd, ent_rdata;

   smx_pkg::alu_op_type                alu_op;
   logic [PW-1:0]                      alu_a, alu_b, alu_res;
   smx_pkg::alu_cmp_type               alu_cmp;

   logic [smx_pkg::ROW_W-1:0]          req_row;
   logic [smx_pkg::COL_W-1:0]          req_col;
   logic [smx_pkg::DATA_W-1:0]         req_val;
   logic                               range_bad;
   logic [63:0]                        old_ext;
   logic [PW-1:0]                      hi_clip;
   logic [smx_pkg::COL_W-1:0]          ent_col;

   smx_alu #(.W(PW)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res),
      .cmp (alu_cmp)
   );

   smx_ptr_ram #(.DEPTH(ROW_LIM + 1), .W(PW)) u_ptr_ram (
      .clock (clock),
      .reset (reset),
      .we    (ptr_we),
      .waddr (ptr_wa),
      .wdata (ptr_wd),
      .raddr (ptr_ra),
      .rdata (ptr_rdata)
   );

   smx_entry_ram #(.DEPTH(CAPACITY), .W(EW)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_wa),
      .wdata (ent_wd),
      .raddr (ent_ra),
      .rdata (ent_rdata)
   );

   assign req_row = req_tdata[5:0];
   assign req_col = req_tdata[11:6];
   assign req_val = req_tdata[43:12];
   assign ent_col = ent_rdata[EW-1:VALUE_WIDTH];
   assign old_ext = 64'($signed(old_ff));
   assign hi_clip = (ptr_rdata > cnt_ff) ? cnt_ff : ptr_rdata;

   assign range_bad = ({1'b0, req_row} >= row_count_ff) || ({1'b0, req_col} >= col_count_ff)
                      || (32'(req_row) >= 32'(MAX_ROWS)) || (32'(req_col) >= 32'(MAX_COLS));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      dec_in       = dec_ff;
      found_in     = found_ff;
      old_in       = old_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      ptr_we       = 1'b0;
      ptr_wa       = '0;
      ptr_wd       = '0;
      ptr_ra       = '0;
      ent_we       = 1'b0;
      ent_wa       = '0;
      ent_wd       = '0;
      ent_ra       = '0;
      alu_op       = smx_pkg::ALU_PASS;
      alu_a        = '0;
      alu_b        = '0;

      if (csr_we) begin
         case (csr_index)
            smx_pkg::REG_ROW_COUNT: row_count_in = csr_wdata;
            smx_pkg::REG_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               row_in    = req_row;
               col_in    = req_col;
               val_in    = VALUE_WIDTH'(64'(req_val));
               found_in  = 1'b0;
               old_in    = '0;
               if (range_bad) begin
                  status_in = smx_pkg::STATUS_RANGE;
                  state_in  = ST_FINISH;
               end else begin
                  status_in = smx_pkg::STATUS_OK;
                  state_in  = ST_PTR_LO;
               end
            end
         end
         ST_PTR_LO: begin
            ptr_ra   = RAW'({1'b0, row_ff});
            state_in = ST_PTR_HI;
         end
         ST_PTR_HI: begin
            lo_in    = ptr_rdata;
            ptr_ra   = RAW'({1'b0, row_ff} + 7'd1);
            state_in = ST_PTR_DONE;
         end
         ST_PTR_DONE: begin
            hi_in    = hi_clip;
            k_in     = (lo_ff > hi_clip) ? hi_clip : lo_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            alu_op = smx_pkg::ALU_PASS;
            alu_a  = k_ff;
            alu_b  = hi_ff;
            if (alu_cmp.lt) begin
               ent_ra   = EAW'(k_ff);
               state_in = ST_SCAN_CHK;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_SCAN_CHK: begin
            alu_op = smx_pkg::ALU_INC;
            alu_a  = k_ff;
            if (ent_col >= col_ff) begin
               found_in = (ent_col == col_ff);
               if (ent_col == col_ff) begin
                  old_in = ent_rdata[VALUE_WIDTH-1:0];
               end
               state_in = ST_DECIDE;
            end else begin
               k_in     = alu_res;
               state_in = ST_SCAN;
            end
         end
         ST_DECIDE: begin
            if (op_ff == smx_pkg::OP_READ) begin
               state_in = ST_FINISH;
            end else if (found_ff) begin
               if (|val_ff) begin
                  ent_we   = 1'b1;
                  ent_wa   = EAW'(k_ff);
                  ent_wd   = {col_ff, val_ff};
                  state_in = ST_FINISH;
               end else begin
                  // removal: pull later entries down by one
                  alu_op = smx_pkg::ALU_INC;
                  alu_a  = k_ff;
                  alu_b  = cnt_ff;
                  dec_in = 1'b1;
                  idx_in = alu_res;
                  wr_in  = k_ff;
                  if (alu_cmp.lt) begin
                     ent_ra   = EAW'(alu_res);
                     state_in = ST_DEL_MOVE;
                  end else begin
                     state_in = ST_SWP_START;
                  end
               end
            end else if (!(|val_ff)) begin
               state_in = ST_FINISH;
            end else if (cnt_ff == PW'(CAPACITY)) begin
               status_in = smx_pkg::STATUS_FULL;
               state_in  = ST_FINISH;
            end else begin
               // insert: push entries from k up by one, last first
               alu_op = smx_pkg::ALU_DEC;
               alu_a  = cnt_ff;
               alu_b  = k_ff;
               dec_in = 1'b0;
               idx_in = alu_res;
               wr_in  = cnt_ff;
               if (alu_cmp.gt) begin
                  ent_ra   = EAW'(alu_res);
                  state_in = ST_INS_MOVE;
               end else begin
                  state_in = ST_INS_PUT;
               end
            end
         end
         ST_DEL_MOVE: begin
            ent_we = 1'b1;
            ent_wa = EAW'(wr_ff);
            ent_wd = ent_rdata;
            alu_op = smx_pkg::ALU_INC;
            alu_a  = idx_ff;
            alu_b  = cnt_ff;
            if (alu_cmp.lt) begin
               ent_ra = EAW'(alu_res);
               idx_in = alu_res;
               wr_in  = idx_ff;
            end else begin
               state_in = ST_SWP_START;
            end
         end
         ST_INS_MOVE: begin
            ent_we = 1'b1;
            ent_wa = EAW'(wr_ff);
            ent_wd = ent_rdata;
            alu_op = smx_pkg::ALU_DEC;
            alu_a  = idx_ff;
            alu_b  = k_ff;
            if (alu_cmp.gt) begin
               ent_ra = EAW'(alu_res);
               idx_in = alu_res;
               wr_in  = idx_ff;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            ent_we   = 1'b1;
            ent_wa   = EAW'(k_ff);
            ent_wd   = {col_ff, val_ff};
            state_in = ST_SWP_START;
         end
         ST_SWP_START: begin
            alu_op   = dec_ff ? smx_pkg::ALU_DEC : smx_pkg::ALU_INC;
            alu_a    = cnt_ff;
            cnt_in   = alu_res;
            p_in     = RAW'({1'b0, row_ff} + 7'd1);
            ptr_ra   = RAW'({1'b0, row_ff} + 7'd1);
            state_in = ST_SWP_MOVE;
         end
         ST_SWP_MOVE: begin
            alu_op = dec_ff ? smx_pkg::ALU_DEC_SAT : smx_pkg::ALU_INC;
            alu_a  = ptr_rdata;
            ptr_we = 1'b1;
            ptr_wa = p_ff;
            ptr_wd = alu_res;
            if (p_ff != RAW'(ROW_LIM)) begin
               p_in   = p_ff + RAW'(1);
               ptr_ra = p_ff + RAW'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {6'd0, status_ff, old_ext[31:0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= smx_pkg::DIM_RESET;
         col_count_ff <= smx_pkg::DIM_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      wr_ff       <= wr_in;
      p_ff        <= p_in;
      dec_ff      <= dec_in;
      found_ff    <= found_in;
      old_ff      <= old_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= PW'(CAPACITY))
      else $error("entry count above capacity");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!ent_we && !ptr_we))
      else $error("memory write while idle");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == smx_pkg::STATUS_FULL)
      |-> (cnt_ff == PW'(CAPACITY)))
      else $error("full status with room left");

   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished request not presented");

endmodule
